/* src/tld_pkg.sv */
// tld_pkg: shared types, codes and constants for the tty line discipline
// no dependencies; used by every module under src
`default_nettype none

package tld_pkg;

  // default depth of the keyboard input fifo
  localparam int IN_DEPTH_DEF = 128;

  // depth of the record queue between front and back
  localparam int QDEPTH = 2;

  // special bytes
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_DEL = 8'h7F;

  // configuration register indexes
  localparam logic [1:0] REG_IN_CRLF  = 2'd0;
  localparam logic [1:0] REG_ECHO     = 2'd1;
  localparam logic [1:0] REG_OUT_CRLF = 2'd2;

  // input item kinds
  typedef enum logic [1:0] {
    FN_KEY   = 2'd0,
    FN_WRITE = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // result channels
  typedef enum logic [1:0] {
    CH_CONSOLE = 2'd0,
    CH_READER  = 2'd1,
    CH_ERASE   = 2'd2,
    CH_STATUS  = 2'd3
  } chan_t;

  // front state
  typedef enum logic {
    FE_IDLE = 1'b0,
    FE_EXEC = 1'b1
  } fe_state_t;

  // one result byte of a record
  typedef struct packed {
    chan_t      channel;
    logic [7:0] data;
  } beat_t;

  // all results of one input item, as handed from front to back
  typedef struct packed {
    beat_t [3:0] beats;
    logic [1:0]  nlast;
    logic        line_done;
    logic        dropped;
    logic        read_empty;
    logic [7:0]  in_count;
    logic [12:0] line_length;
  } rec_t;

  // handshake between front and record queue
  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

endpackage

`default_nettype wire

/* src/tld_front.sv */
// tld_front: accepts items, holds the input fifo, counters and config registers,
// and turns each item into one result record. depends on tld_pkg
`default_nettype none

module tld_front #(
  parameter int IN_DEPTH = tld_pkg::IN_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [23:0]    s_tdata,   // data_byte[7:0], read_size[20:8], zero fill
  input  wire logic [1:0]     s_tuser,   // func[1:0]
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [0:0]     cfg_data,
  input  wire logic           q_full,
  output tld_pkg::q_wr_t      q_wr
);

  localparam int PW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int FW = $clog2(IN_DEPTH + 1);

  // input byte store
  logic [7:0] mem [IN_DEPTH];
  logic [7:0] rd_data;

  logic [PW-1:0] rp, rp_next, wp, wp_next;
  logic [FW-1:0] fill, fill_next;
  logic [12:0]   del, del_next, len_shown;

  logic in_crlf, echo_enable, out_crlf;

  tld_pkg::fe_state_t state, state_next;
  tld_pkg::func_t     func_q;
  logic [7:0]         data_q;
  logic [12:0]        size_q;

  logic         accept, we, done, dropped, empty;
  logic [2:0]   n;
  tld_pkg::rec_t rec;

  assign accept = s_tvalid && s_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tld_pkg::FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ready
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      tld_pkg::FE_IDLE: begin
        s_tready = !q_full;
        if (s_tvalid && !q_full) state_next = tld_pkg::FE_EXEC;
      end
      tld_pkg::FE_EXEC: begin
        state_next = tld_pkg::FE_IDLE;
      end
      default: state_next = tld_pkg::FE_IDLE;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= tld_pkg::func_t'(s_tuser);
      data_q <= s_tdata[7:0];
      size_q <= s_tdata[20:8];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_crlf     <= 1'b1;
      echo_enable <= 1'b1;
      out_crlf    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tld_pkg::REG_IN_CRLF:  in_crlf     <= cfg_data[0];
        tld_pkg::REG_ECHO:     echo_enable <= cfg_data[0];
        tld_pkg::REG_OUT_CRLF: out_crlf    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // store: write on keyboard exec, registered read at the head
  always_ff @(posedge clk) begin
    if (we) mem[wp] <= data_q;
    rd_data <= mem[rp];
  end

  // execute one item and build its record
  always_comb begin
    rec       = '0;
    n         = 3'd0;
    rp_next   = rp;
    wp_next   = wp;
    fill_next = fill;
    del_next  = del;
    done      = 1'b0;
    dropped   = 1'b0;
    empty     = 1'b0;
    we        = 1'b0;
    case (func_q)
      tld_pkg::FN_KEY: begin
        if (fill >= FW'(IN_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          we        = (state == tld_pkg::FE_EXEC);
          wp_next   = (wp == PW'(IN_DEPTH - 1)) ? '0 : wp + PW'(1);
          fill_next = fill + FW'(1);
        end
        rec.beats[n[1:0]] = '{tld_pkg::CH_STATUS, 8'h00};
        n = n + 3'd1;
      end
      tld_pkg::FN_WRITE: begin
        if (data_q == tld_pkg::BYTE_LF && out_crlf) begin
          rec.beats[n[1:0]] = '{tld_pkg::CH_CONSOLE, tld_pkg::BYTE_CR};
          n = n + 3'd1;
        end
        rec.beats[n[1:0]] = '{tld_pkg::CH_CONSOLE, data_q};
        n = n + 3'd1;
      end
      tld_pkg::FN_READ: begin
        if (del >= size_q) begin
          // reader already full
          done = 1'b1;
          rec.beats[n[1:0]] = '{tld_pkg::CH_STATUS, 8'h00};
          n = n + 3'd1;
        end else if (fill == '0) begin
          empty = 1'b1;
          rec.beats[n[1:0]] = '{tld_pkg::CH_STATUS, 8'h00};
          n = n + 3'd1;
        end else begin
          rp_next   = (rp == PW'(IN_DEPTH - 1)) ? '0 : rp + PW'(1);
          fill_next = fill - FW'(1);
          if (rd_data == tld_pkg::BYTE_DEL && del == '0) begin
            // erase at line start
            rec.beats[n[1:0]] = '{tld_pkg::CH_STATUS, 8'h00};
            n = n + 3'd1;
          end else begin
            if (rd_data == tld_pkg::BYTE_LF) begin
              if (in_crlf && ({1'b0, del} + 14'd1 < {1'b0, size_q})) begin
                rec.beats[n[1:0]] = '{tld_pkg::CH_READER, tld_pkg::BYTE_CR};
                n = n + 3'd1;
                del_next = del_next + 13'd1;
              end
              rec.beats[n[1:0]] = '{tld_pkg::CH_READER, tld_pkg::BYTE_LF};
              n = n + 3'd1;
              del_next = del_next + 13'd1;
            end else if (rd_data == tld_pkg::BYTE_DEL) begin
              rec.beats[n[1:0]] = '{tld_pkg::CH_ERASE, 8'h00};
              n = n + 3'd1;
              del_next = del_next - 13'd1;
            end else begin
              rec.beats[n[1:0]] = '{tld_pkg::CH_READER, rd_data};
              n = n + 3'd1;
              del_next = del_next + 13'd1;
            end
            // echo through output conversion
            if (echo_enable) begin
              if (rd_data == tld_pkg::BYTE_LF && out_crlf) begin
                rec.beats[n[1:0]] = '{tld_pkg::CH_CONSOLE, tld_pkg::BYTE_CR};
                n = n + 3'd1;
              end
              rec.beats[n[1:0]] = '{tld_pkg::CH_CONSOLE, rd_data};
              n = n + 3'd1;
            end
            if (rd_data == tld_pkg::BYTE_LF || rd_data == tld_pkg::BYTE_CR ||
                del_next >= size_q) begin
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        rec.beats[n[1:0]] = '{tld_pkg::CH_STATUS, 8'h00};
        n = n + 3'd1;
      end
    endcase
    len_shown       = del_next;
    rec.nlast       = 2'(n - 3'd1);
    rec.line_done   = done;
    rec.dropped     = dropped;
    rec.read_empty  = empty;
    rec.in_count    = 8'(fill_next);
    rec.line_length = len_shown;
  end

  // state update at exec
  always_ff @(posedge clk) begin
    if (rst) begin
      rp   <= '0;
      wp   <= '0;
      fill <= '0;
      del  <= '0;
    end else if (state == tld_pkg::FE_EXEC) begin
      rp   <= rp_next;
      wp   <= wp_next;
      fill <= fill_next;
      del  <= done ? 13'd0 : del_next;
    end
  end

  assign q_wr.push = (state == tld_pkg::FE_EXEC);
  assign q_wr.rec  = rec;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(IN_DEPTH))
    else $error("input fifo count above depth");
  a_accept_push: assert property (@(posedge clk) disable iff (rst)
    accept |=> q_wr.push)
    else $error("accepted item produced no record");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("record pushed into full queue");
`endif

endmodule

`default_nettype wire

/* src/tld_queue.sv */
// tld_queue: short record queue between front and back
// depends on tld_pkg
`default_nettype none

module tld_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tld_pkg::q_wr_t q_wr,
  output logic                full,
  output logic                head_valid,
  output tld_pkg::rec_t       head,
  input  wire logic           pop
);

  localparam int QAW = (tld_pkg::QDEPTH > 1) ? $clog2(tld_pkg::QDEPTH) : 1;
  localparam int QCW = $clog2(tld_pkg::QDEPTH + 1);

  tld_pkg::rec_t  entries [tld_pkg::QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] count;
  logic           do_push, do_pop;

  assign full       = (count == QCW'(tld_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= q_wr.rec;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == QAW'(tld_pkg::QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      if (do_pop)  rptr <= (rptr == QAW'(tld_pkg::QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      count <= count + QCW'(do_push) - QCW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(tld_pkg::QDEPTH))
    else $error("record queue count above depth");
  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !full)
    else $error("record pushed while queue full");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("record popped from empty queue");
`endif

endmodule

`default_nettype wire

/* src/tld_back.sv */
// tld_back: walks the head record of the queue and sends one result beat per cycle
// while m_tready is high; depends on tld_pkg
`default_nettype none

module tld_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire tld_pkg::rec_t  head,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [31:0]         m_tdata,   // out_byte[7:0], line_done[8], dropped[9],
                                         // read_empty[10], in_count[18:11],
                                         // line_length[31:19]
  output logic [1:0]          m_tuser,   // channel[1:0]
  output logic                m_tlast
);

  logic [1:0]     idx;
  tld_pkg::beat_t cur;
  logic           beat_done;

  assign cur       = head.beats[idx];
  assign m_tvalid  = head_valid;
  assign m_tlast   = (idx == head.nlast);
  assign m_tuser   = cur.channel;
  assign m_tdata   = {head.line_length, head.in_count, head.read_empty,
                      head.dropped, head.line_done, cur.data};
  assign beat_done = m_tvalid && m_tready;
  assign pop       = beat_done && m_tlast;

  // beat index within the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat_done) begin
      idx <= m_tlast ? 2'd0 : idx + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.nlast)
    else $error("beat index past end of record");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 2'd0)
    else $error("beat index left over without a record");
  a_pop_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 2'd0)
    else $error("beat index not cleared after record");
`endif

endmodule

`default_nettype wire

/* src/tty_line_discipline_top.sv */
// tty line discipline: an accepted item is executed in the front's exec state and its
// record is pushed into the record queue, which raises m_tvalid; its results then
// follow one beat per cycle while m_tready is high, up to four.
// the front takes no new item while executing one or while the record queue is full;
// an item with n results gives n beats on the output.
// reset (synchronous, rst high) clears fifo pointers, counts, queue and sets all
// config bits to one; the input store contents stay undefined until written.
`default_nettype none

module tty_line_discipline_top #(
  parameter int IN_DEPTH = tld_pkg::IN_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // data_byte[7:0], read_size[20:8], zero fill
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_byte[7:0], line_done[8], dropped[9],
                                      // read_empty[10], in_count[18:11],
                                      // line_length[31:19]
  output logic [1:0]       m_tuser,   // channel[1:0]
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [0:0]  cfg_data
);

  tld_pkg::q_wr_t q_wr;
  tld_pkg::rec_t  head;
  logic           q_full, head_valid, pop;

  // front: accept, fifo, execute
  tld_front #(.IN_DEPTH(IN_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // record queue
  tld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .q_wr       (q_wr),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: result beats
  tld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

/* test/tty_line_discipline_top_tb.sv */
// tty_line_discipline_top_tb: self-checking bench for the tty line discipline top level
// drives keyboard, host write and read beats, predicts every result beat and compares
// depends on src/tld_pkg.sv and src/tty_line_discipline_top.sv
`default_nettype none

module tty_line_discipline_top_tb;

  localparam int IN_DEPTH    = tld_pkg::IN_DEPTH_DEF;
  localparam int ITEM_TARGET = 430;

  // one predicted result beat
  typedef struct {
    tld_pkg::chan_t channel;
    logic [7:0]     out_byte;
    logic           line_done;
    logic           dropped;
    logic           read_empty;
    logic [7:0]     in_count;
    logic [12:0]    line_length;
    logic           last;
  } tty_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // data_byte[7:0], read_size[20:8], zero fill
  logic [1:0]  s_tuser;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // out_byte[7:0], line_done[8], dropped[9], read_empty[10],
                          // in_count[18:11], line_length[31:19]
  logic [1:0]  m_tuser;   // channel[1:0]
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [0:0]  cfg_data;

  // predictor state: queued keyboard bytes, delivered count, register copies
  logic [7:0]  kbd_fifo[$];
  int          line_len = 0;
  bit          crlf_in = 1'b1;
  bit          echo_on = 1'b1;
  bit          crlf_out = 1'b1;

  tty_result_t step_beats[$];
  tty_result_t tty_results[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;

  tty_line_discipline_top #(.IN_DEPTH(IN_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void emit_beat(tld_pkg::chan_t ch, logic [7:0] b);
    tty_result_t r;
    r.channel  = ch;
    r.out_byte = b;
    step_beats.push_back(r);
  endfunction

  // console output with optional newline expansion
  function automatic void console_beat(logic [7:0] c);
    if (c == tld_pkg::BYTE_LF && crlf_out) emit_beat(tld_pkg::CH_CONSOLE, tld_pkg::BYTE_CR);
    emit_beat(tld_pkg::CH_CONSOLE, c);
  endfunction

  // result beats of one accepted item, appended to tty_results
  function automatic void ldisc_step(tld_pkg::func_t fn, logic [7:0] b, logic [12:0] sz);
    bit          done;
    bit          drop;
    bit          empty;
    logic [7:0]  c;
    logic [12:0] shown;
    done  = 1'b0;
    drop  = 1'b0;
    empty = 1'b0;
    step_beats.delete();
    case (fn)
      tld_pkg::FN_KEY: begin
        if (kbd_fifo.size() >= IN_DEPTH) drop = 1'b1;
        else kbd_fifo.push_back(b);
        emit_beat(tld_pkg::CH_STATUS, 8'h00);
      end
      tld_pkg::FN_WRITE: begin
        console_beat(b);
      end
      tld_pkg::FN_READ: begin
        if (line_len >= int'(sz)) begin
          // reader already full: nothing consumed
          done = 1'b1;
          emit_beat(tld_pkg::CH_STATUS, 8'h00);
        end else if (kbd_fifo.size() == 0) begin
          empty = 1'b1;
          emit_beat(tld_pkg::CH_STATUS, 8'h00);
        end else begin
          c = kbd_fifo.pop_front();
          if (c == tld_pkg::BYTE_DEL && line_len == 0) begin
            // erase with nothing to erase: swallowed silently
            emit_beat(tld_pkg::CH_STATUS, 8'h00);
          end else begin
            if (c == tld_pkg::BYTE_LF) begin
              if (crlf_in && line_len + 1 < int'(sz)) begin
                emit_beat(tld_pkg::CH_READER, tld_pkg::BYTE_CR);
                line_len++;
              end
              emit_beat(tld_pkg::CH_READER, tld_pkg::BYTE_LF);
              line_len++;
            end else if (c == tld_pkg::BYTE_DEL) begin
              emit_beat(tld_pkg::CH_ERASE, 8'h00);
              line_len--;
            end else begin
              emit_beat(tld_pkg::CH_READER, c);
              line_len++;
            end
            if (echo_on) console_beat(c);
            if (c == tld_pkg::BYTE_LF || c == tld_pkg::BYTE_CR || line_len >= int'(sz))
              done = 1'b1;
          end
        end
      end
      default: begin
        emit_beat(tld_pkg::CH_STATUS, 8'h00);
      end
    endcase
    shown = 13'(line_len);
    if (done) line_len = 0;
    foreach (step_beats[k]) begin
      step_beats[k].line_done   = done;
      step_beats[k].dropped     = drop;
      step_beats[k].read_empty  = empty;
      step_beats[k].in_count    = 8'(kbd_fifo.size());
      step_beats[k].line_length = shown;
      step_beats[k].last        = (k == step_beats.size() - 1);
      tty_results.push_back(step_beats[k]);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 200)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    tty_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tty_results.size() == 0) begin
        if (mismatches < 200)
          $display("%0t: unexpected beat, expected none, actual tuser %0h tdata %0h",
                   $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = tty_results.pop_front();
        check_field("channel", want.channel, m_tuser);
        check_field("out_byte", want.out_byte, m_tdata[7:0]);
        check_field("line_done", want.line_done, m_tdata[8]);
        check_field("dropped", want.dropped, m_tdata[9]);
        check_field("read_empty", want.read_empty, m_tdata[10]);
        check_field("in_count", want.in_count, m_tdata[18:11]);
        check_field("line_length", want.line_length, m_tdata[31:19]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // reader size: mostly small, some full-size and some anywhere in range
  function automatic logic [12:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 13'($urandom_range(1, 16));
    if (r < 80) return 13'($urandom_range(17, 200));
    if (r < 90) return 13'd4096;
    return 13'($urandom_range(1, 4096));
  endfunction

  // keyboard byte with line controls more frequent than chance
  function automatic logic [7:0] pick_key_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return tld_pkg::BYTE_LF;
    if (r < 10) return tld_pkg::BYTE_CR;
    if (r < 15) return tld_pkg::BYTE_DEL;
    return 8'($urandom);
  endfunction

  // output side stalls
  initial begin
    int hold;
    m_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (m_tready) begin
        hold = pick_gap();
        if (hold > 0) begin
          m_tready <= 1'b0;
          hold--;
        end else begin
          hold = $urandom_range(0, 4);
        end
      end else begin
        m_tready <= 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  // send one input beat and predict it once accepted
  task automatic send_item(input tld_pkg::func_t fn, input logic [7:0] b,
                           input logic [12:0] sz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      s_tuser  <= 2'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {3'b000, sz, b};
    do @(posedge clk); while (!s_tready);
    ldisc_step(fn, b, sz);
    if (fn != tld_pkg::FN_NONE) items_sent++;
  endtask

  // stop sending and let every predicted beat come out
  task automatic wait_drained();
    int waited;
    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (tty_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (tty_results.size() != 0) begin
      $display("%0t: %0d expected beats, actual none", $time, tty_results.size());
      mismatches++;
      tty_results.delete();
    end
    repeat (6) @(negedge clk);
  endtask

  // write all three registers, block idle
  task automatic load_config(input bit in_cr, input bit echo, input bit out_cr);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tld_pkg::REG_IN_CRLF;
    cfg_data  <= in_cr;
    @(negedge clk);
    cfg_index <= tld_pkg::REG_ECHO;
    cfg_data  <= echo;
    @(negedge clk);
    cfg_index <= tld_pkg::REG_OUT_CRLF;
    cfg_data  <= out_cr;
    @(negedge clk);
    cfg_we <= 1'b0;
    crlf_in  = in_cr;
    echo_on  = echo;
    crlf_out = out_cr;
  endtask

  // type a line, then read until the input fifo runs dry
  task automatic run_line();
    int body;
    int r;
    logic [12:0] sz;
    body = $urandom_range(0, 10);
    repeat (body) begin
      r = $urandom_range(0, 99);
      send_item(tld_pkg::FN_KEY, (r < 12) ? tld_pkg::BYTE_DEL : 8'($urandom), pick_size());
    end
    r = $urandom_range(0, 99);
    if (r < 45) send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_LF, pick_size());
    else if (r < 80) send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_CR, pick_size());
    sz = pick_size();
    while (kbd_fifo.size() != 0) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        send_item(tld_pkg::FN_WRITE, pick_key_byte(), pick_size());
      else if (r < 18)
        send_item(tld_pkg::FN_READ, 8'($urandom),
                  13'($urandom_range(1, (line_len > 1) ? line_len : 1)));
      else
        send_item(tld_pkg::FN_READ, 8'($urandom), sz);
    end
    if ($urandom_range(0, 3) == 0) send_item(tld_pkg::FN_READ, 8'($urandom), sz);
  endtask

  // a few unrelated key, write or read beats
  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_item(tld_pkg::func_t'($urandom_range(0, 2)), 8'($urandom), pick_size());
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings: extremes and each corner of the read path
  task automatic test_directed();
    send_item(tld_pkg::FN_READ, 8'h00, 13'd1);
    send_item(tld_pkg::FN_NONE, 8'hA5, 13'd7);
    send_item(tld_pkg::FN_WRITE, 8'h00, 13'd1);
    send_item(tld_pkg::FN_WRITE, 8'hFF, 13'd4096);
    send_item(tld_pkg::FN_WRITE, tld_pkg::BYTE_LF, 13'd1);
    // erase at line start, plain byte, erase mid-line, top byte, newline
    send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_DEL, 13'd1);
    send_item(tld_pkg::FN_KEY, 8'h41, 13'd4096);
    send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_DEL, 13'd1);
    send_item(tld_pkg::FN_KEY, 8'hFF, 13'd1);
    send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_LF, 13'd1);
    repeat (5) send_item(tld_pkg::FN_READ, 8'hFF, 13'd4096);
    // size reached, reader already full after lowering size, zero size
    send_item(tld_pkg::FN_KEY, 8'h00, 13'd1);
    send_item(tld_pkg::FN_KEY, 8'h80, 13'd1);
    send_item(tld_pkg::FN_READ, 8'h00, 13'd1);
    send_item(tld_pkg::FN_READ, 8'h00, 13'd3);
    send_item(tld_pkg::FN_READ, 8'h00, 13'd1);
    send_item(tld_pkg::FN_READ, 8'h00, 13'd0);
    // newline with no room for the inserted CR
    send_item(tld_pkg::FN_KEY, tld_pkg::BYTE_LF, 13'd1);
    send_item(tld_pkg::FN_READ, 8'h00, 13'd1);
  endtask

  // fill the input fifo past full, then drain it
  task automatic test_fifo_overflow();
    no_idle = 1'b1;
    repeat (IN_DEPTH + 3) send_item(tld_pkg::FN_KEY, pick_key_byte(), pick_size());
    no_idle = 1'b0;
    while (kbd_fifo.size() != 0) send_item(tld_pkg::FN_READ, 8'($urandom), pick_size());
  endtask

  // every register setting, all off and all on included
  task automatic test_config_sweep();
    for (int k = 0; k < 8; k++) begin
      wait_drained();
      load_config(k[0], k[1], k[2]);
      no_idle = (k % 3 == 0);
      run_line();
    end
    no_idle = 1'b0;
  endtask

  // mostly well-formed lines, some noise, settings changed between phases
  task automatic test_random_traffic();
    int phase_start;
    phase_start = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent - phase_start >= 40) begin
        wait_drained();
        load_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        no_idle = ($urandom_range(0, 4) == 0);
        phase_start = items_sent;
      end
      if ($urandom_range(0, 99) < 80) run_line();
      else run_noise();
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fifo_overflow();
    test_config_sweep();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

/* tty_line_discipline_top.f */
src/tld_pkg.sv
src/tld_front.sv
src/tld_queue.sv
src/tld_back.sv
src/tty_line_discipline_top.sv
test/tty_line_discipline_top_tb.sv
